// ===== hw/rtl/frt_pkg.sv =====
package frt_pkg;

  localparam int RangeSlotsDef = 16;
  localparam int RingDepthDef  = 16;
  localparam int PageShiftDef  = 12;

  localparam int AddrW = 64;
  localparam int ModeW = 3;
  localparam int StatW = 3;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_FAULT      = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_FULL        = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_RING_FULL   = 3'd4,
    ST_NOT_HANDLED = 3'd5,
    ST_RING_EMPTY  = 3'd6
  } status_t;

  localparam logic [ModeW-1:0] ModeWp    = 3'd2;
  localparam logic [ModeW-1:0] ModeMinor = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_PLACE,
    S_FAULT,
    S_READ,
    S_READ_WAIT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic check;      // capture range bounds for the scan
    logic scan_step;  // process slot at scan index
    logic scan_clr;   // reset scan index
    logic place;      // write merged range into first free slot
    logic fault_eval; // evaluate fault lookup and enqueue
    logic read_issue; // read state marker, unused by the datapath
    logic read_take;  // pop ring entry into result
    logic set_status; // take status from ctl
    logic [StatW-1:0] status;
  } frt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic scan_last;
    logic hit;
    logic has_free;
    logic ring_empty;
  } frt_stat_t;

endpackage

// ===== hw/rtl/frt_ram.sv =====
module frt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/frt_ctrl.sv =====
module frt_ctrl import frt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic [1:0] op,
  input  logic      out_busy,
  input  frt_stat_t st,
  output frt_cmd_t  cmd,
  output logic      in_ready,
  output logic      res_valid
);
  state_t state, state_next;
  op_t    opr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      opr   <= OP_REGISTER;
    end else begin
      state <= state_next;
      if (in_fire) opr <= op_t'(op);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_fire) begin
        case (op_t'(op))
          OP_FAULT: state_next = S_FAULT;
          OP_READ:  state_next = S_READ;
          default:  state_next = S_CHECK;
        endcase
      end
      S_CHECK:     state_next = st.bad ? S_DONE : S_SCAN;
      S_SCAN:      if (st.scan_last) state_next = (opr == OP_REGISTER) ? S_PLACE : S_DONE;
      S_PLACE:     state_next = S_DONE;
      S_FAULT:     state_next = S_DONE;
      S_READ:      state_next = st.ring_empty ? S_DONE : S_READ_WAIT;
      S_READ_WAIT: state_next = S_DONE;
      S_DONE:      if (!out_busy) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      S_CHECK: begin
        cmd.check    = 1'b1;
        cmd.scan_clr = 1'b1;
        if (st.bad) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_INVALID;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last && opr == OP_UNREGISTER) begin
          cmd.set_status = 1'b1;
          cmd.status     = st.hit ? ST_OK : ST_NOT_FOUND;
        end
      end
      S_PLACE: begin
        cmd.place      = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status     = st.has_free ? ST_OK : ST_FULL;
      end
      S_FAULT: cmd.fault_eval = 1'b1;
      S_READ: begin
        cmd.read_issue = 1'b1;
        if (st.ring_empty) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_RING_EMPTY;
        end
      end
      S_READ_WAIT: cmd.read_take = 1'b1;
      S_DONE:      res_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/frt_dp.sv =====
module frt_dp import frt_pkg::*; #(
  parameter int RangeSlots = RangeSlotsDef,
  parameter int RingDepth  = RingDepthDef,
  parameter int PageShift  = PageShiftDef
) (
  input  logic             clk,
  input  logic             rst,
  input  frt_cmd_t         cmd,
  output frt_stat_t        st,
  input  logic             sigbus_mode,
  input  logic [AddrW-1:0] in_address,
  input  logic [AddrW-1:0] in_length,
  input  logic [ModeW-1:0] in_mode,
  input  logic             in_write,
  input  logic             in_minor,
  input  logic [1:0]       in_op,
  output logic [StatW-1:0] status,
  output logic             sigbus_raised,
  output logic [AddrW-1:0] event_address,
  output logic             event_write,
  output logic             event_minor
);
  localparam int SlotW = (RangeSlots > 1) ? $clog2(RangeSlots) : 1;
  localparam int RingW = $clog2(RingDepth);

  logic [AddrW-1:0] rbeg [RangeSlots];
  logic [AddrW-1:0] rlim [RangeSlots];
  logic [ModeW-1:0] rmode [RangeSlots];
  logic [RangeSlots-1:0] rvalid;

  logic [AddrW-1:0] addr, len, lo, hi;
  logic [ModeW-1:0] mode, m;
  logic             wr, mn, hit;
  logic [1:0]       opr;
  logic [SlotW-1:0] idx;
  logic [RingW-1:0] head, tail;

  // split right part queued until the free slot is known next step
  logic             pend;
  logic [AddrW-1:0] pend_b, pend_l;
  logic [ModeW-1:0] pend_m;

  logic [AddrW:0]   sum;
  logic [AddrW-1:0] pmask;
  assign pmask = (AddrW)'((65'd1 << PageShift) - 65'd1);
  assign sum   = {1'b0, addr} + {1'b0, len};

  assign st.bad = (len == '0) || sum[AddrW] || ((addr & pmask) != '0) ||
                  ((len & pmask) != '0) ||
                  ((opr == OP_REGISTER) && (mode == '0));

  // first free slot, priority over valid bits
  logic             free_ok;
  logic [SlotW-1:0] free_idx;
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = RangeSlots - 1; i >= 0; i--) begin
      if (!rvalid[i]) begin
        free_ok  = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  logic [AddrW-1:0] cb, cl;
  logic             ov, split_now;
  assign cb = rbeg[idx];
  assign cl = rlim[idx];
  assign ov = rvalid[idx] && (lo < cl) && (cb < hi);
  assign split_now = !pend && ov && (opr == OP_UNREGISTER) && (lo > cb) && (hi < cl);

  // a split on the last slot still needs its placement step
  assign st.scan_last  = (idx == SlotW'(RangeSlots - 1)) && !split_now;
  assign st.hit        = hit || (!pend && ov);
  assign st.has_free   = free_ok;
  assign st.ring_empty = (head == tail);

  // fault lookup, first covering slot
  logic             f_hit;
  logic [ModeW-1:0] f_mode;
  always_comb begin
    f_hit  = 1'b0;
    f_mode = '0;
    for (int i = RangeSlots - 1; i >= 0; i--) begin
      if (rvalid[i] && addr >= rbeg[i] && addr < rlim[i]) begin
        f_hit  = 1'b1;
        f_mode = rmode[i];
      end
    end
  end

  logic [RingW-1:0] head_inc, tail_inc;
  assign head_inc = (head == RingW'(RingDepth - 1)) ? '0 : head + RingW'(1);
  assign tail_inc = (tail == RingW'(RingDepth - 1)) ? '0 : tail + RingW'(1);

  logic             ev_we;
  logic [AddrW+1:0] ev_rd;
  assign ev_we = cmd.fault_eval && f_hit && !(mn && !(|(f_mode & ModeMinor))) &&
                 !(wr && !(|(f_mode & ModeWp))) && !sigbus_mode && (head_inc != tail);

  frt_ram #(.Width(AddrW + 2), .Depth(RingDepth)) u_ring (
    .clk   (clk),
    .we    (ev_we),
    .waddr (head),
    .wdata ({mn, wr, addr}),
    .raddr (tail),
    .rdata (ev_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= '0;
      head   <= '0;
      tail   <= '0;
      pend   <= 1'b0;
    end else begin
      if (cmd.scan_step && pend) begin
        pend <= 1'b0;
        if (free_ok) begin
          rbeg[free_idx]   <= pend_b;
          rlim[free_idx]   <= pend_l;
          rmode[free_idx]  <= pend_m;
          rvalid[free_idx] <= 1'b1;
        end
      end else if (cmd.scan_step && ov) begin
        if (opr == OP_REGISTER) begin
          rvalid[idx] <= 1'b0;
        end else if (lo <= cb && hi >= cl) begin
          rvalid[idx] <= 1'b0;
        end else if (lo > cb && hi < cl) begin
          rlim[idx] <= lo;
          pend      <= 1'b1;
        end else if (lo <= cb) begin
          rbeg[idx] <= hi;
        end else begin
          rlim[idx] <= lo;
        end
      end
      if (cmd.place && free_ok) begin
        rbeg[free_idx]   <= lo;
        rlim[free_idx]   <= hi;
        rmode[free_idx]  <= m;
        rvalid[free_idx] <= 1'b1;
      end
      if (ev_we) head <= head_inc;
      if (cmd.read_take) tail <= tail_inc;
    end
  end

  // scan index holds on the step that splits a range; the placement step then advances it
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= in_address;
      len  <= in_length;
      mode <= in_mode;
      wr   <= in_write;
      mn   <= in_minor;
      opr  <= in_op;
      status        <= ST_OK;
      sigbus_raised <= 1'b0;
      event_address <= '0;
      event_write   <= 1'b0;
      event_minor   <= 1'b0;
    end
    if (cmd.check) begin
      lo  <= addr;
      hi  <= sum[AddrW-1:0];
      m   <= mode;
      hit <= 1'b0;
    end
    if (cmd.scan_clr) idx <= '0;
    if (cmd.scan_step) begin
      if (!pend) begin
        if (ov) begin
          hit <= 1'b1;
          if (opr == OP_REGISTER) begin
            if (cb < lo) lo <= cb;
            if (cl > hi) hi <= cl;
            m <= m | rmode[idx];
          end else if (lo > cb && hi < cl) begin
            pend_b <= hi;
            pend_l <= cl;
            pend_m <= rmode[idx];
          end
        end
        if (!(ov && opr == OP_UNREGISTER && lo > cb && hi < cl) && !st.scan_last)
          idx <= idx + SlotW'(1);
      end else if (!st.scan_last) begin
        idx <= idx + SlotW'(1);
      end
    end
    if (cmd.fault_eval) begin
      if (!f_hit || (mn && !(|(f_mode & ModeMinor))) || (wr && !(|(f_mode & ModeWp))))
        status <= ST_NOT_HANDLED;
      else if (sigbus_mode)
        sigbus_raised <= 1'b1;
      else if (head_inc == tail)
        status <= ST_RING_FULL;
    end
    if (cmd.read_take) begin
      event_address <= ev_rd[AddrW-1:0];
      event_write   <= ev_rd[AddrW];
      event_minor   <= ev_rd[AddrW+1];
    end
    if (cmd.set_status) status <= cmd.status;
  end
endmodule

// ===== hw/rtl/fault_range_tracker.sv =====
// port    dir  handshake          content
// s_axis  in   tvalid/tready      tuser: operation
//                                 tdata: address, length, mode_flags, is_write, minor flag
// m_axis  out  tvalid/tready      tdata: status, sigbus_raised, event_address, event_write,
//                                        event_minor
// cfg     in   cfg_valid/ready    cfg_data: sigbus_mode
// the table is scanned one slot per cycle, and a split adds a placement step for its right
// part; register ends with a placement step after the scan; the ring has a registered read.
// one word at a time; s_axis_tready stays low until the result word has been taken, and
// m_axis_tready low holds the result word. rst clears valid bits, ring pointers and
// sigbus_mode; the ring contents need no clearing
module fault_range_tracker import frt_pkg::*; #(
  parameter int RANGE_SLOTS = RangeSlotsDef,
  parameter int RING_DEPTH  = RingDepthDef,
  parameter int PAGE_SHIFT  = PageShiftDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,   // operation
  input  logic [135:0] s_axis_tdata,   // address, length, mode_flags, is_write, minor flag
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,   // status, sigbus_raised, event_address, event_write, event_minor
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);
  frt_cmd_t  cmd;
  frt_stat_t st;
  logic      sigbus_mode, in_fire;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) sigbus_mode <= 1'b0;
    else if (cfg_valid) sigbus_mode <= cfg_data;
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  logic [StatW-1:0] status;
  logic             sig_r, ev_w, ev_m;
  logic [AddrW-1:0] ev_a;

  frt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .op        (s_axis_tuser),
    .out_busy  (!m_axis_tready),
    .st        (st),
    .cmd       (cmd),
    .in_ready  (s_axis_tready),
    .res_valid (m_axis_tvalid)
  );

  frt_dp #(
    .RangeSlots (RANGE_SLOTS),
    .RingDepth  (RING_DEPTH),
    .PageShift  (PAGE_SHIFT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .sigbus_mode   (sigbus_mode),
    .in_address    (s_axis_tdata[63:0]),
    .in_length     (s_axis_tdata[127:64]),
    .in_mode       (s_axis_tdata[130:128]),
    .in_write      (s_axis_tdata[131]),
    .in_minor      (s_axis_tdata[132]),
    .in_op         (s_axis_tuser),
    .status        (status),
    .sigbus_raised (sig_r),
    .event_address (ev_a),
    .event_write   (ev_w),
    .event_minor   (ev_m)
  );

  assign m_axis_tdata = {2'b00, ev_m, ev_w, ev_a, sig_r, status};
endmodule

// ===== dv/fault_range_tracker_test.sv =====
module fault_range_tracker_test;
  import frt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots = 16;
  localparam int Ring = 16;
  localparam int PShift = 12;
  localparam longint unsigned Page = 64'd1 << PShift;
  localparam longint CycleLimit = 2_000_000;

  typedef struct packed {
    logic       ev_minor;
    logic       ev_write;
    logic [63:0] ev_addr;
    logic       bus_err;
    status_t    status;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [1:0] s_axis_tuser = '0;    // operation
  logic [135:0] s_axis_tdata = '0;  // address, length, mode_flags, is_write, minor flag
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // status, sigbus_raised, event_address, event_write, event_minor
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  fault_range_tracker i_dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  // shadow of the range table and the event ring
  logic [63:0] tb_begin [Slots];
  logic [63:0] tb_limit [Slots];
  logic [2:0]  tb_mode [Slots];
  logic        tb_valid [Slots];
  logic [63:0] ring_addr [Ring];
  logic [1:0]  ring_kind [Ring];
  int unsigned ring_wr, ring_rd;
  logic bus_err_mode;

  result_t expected_results[$];
  int errors, items_sent, results_seen, long_stall;
  int status_seen[7];
  longint cycles;

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end
  initial cycles = 0;

  function automatic bit span_bad(logic [63:0] a, logic [63:0] len);
    logic [64:0] sum;
    sum = {1'b0, a} + {1'b0, len};
    return len == 0 || sum[64] || a[PShift-1:0] != 0 || len[PShift-1:0] != 0;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < Slots; i++)
      if (!tb_valid[i]) return i;
    return -1;
  endfunction

  function automatic status_t table_insert(logic [63:0] a, logic [63:0] len, logic [2:0] m);
    logic [63:0] lo, hi;
    logic [2:0] mm;
    int s;
    if (span_bad(a, len) || m == 0) return ST_INVALID;
    lo = a; hi = a + len; mm = m;
    for (int i = 0; i < Slots; i++) begin
      if (tb_valid[i] && lo < tb_limit[i] && tb_begin[i] < hi) begin
        if (tb_begin[i] < lo) lo = tb_begin[i];
        if (tb_limit[i] > hi) hi = tb_limit[i];
        mm |= tb_mode[i];
        tb_valid[i] = 1'b0;
      end
    end
    s = free_slot();
    if (s < 0) return ST_FULL;
    tb_begin[s] = lo; tb_limit[s] = hi; tb_mode[s] = mm; tb_valid[s] = 1'b1;
    return ST_OK;
  endfunction

  function automatic status_t table_cut(logic [63:0] a, logic [63:0] len);
    logic [63:0] lo, hi, rb, rl;
    bit hit;
    int s;
    if (span_bad(a, len)) return ST_INVALID;
    lo = a; hi = a + len; hit = 0;
    for (int i = 0; i < Slots; i++) begin
      if (!tb_valid[i]) continue;
      rb = tb_begin[i]; rl = tb_limit[i];
      if (!(lo < rl && rb < hi)) continue;
      hit = 1;
      if (lo <= rb && hi >= rl) tb_valid[i] = 1'b0;
      else if (lo > rb && hi < rl) begin
        tb_limit[i] = lo;
        s = free_slot();
        if (s >= 0) begin
          tb_begin[s] = hi; tb_limit[s] = rl; tb_mode[s] = tb_mode[i]; tb_valid[s] = 1'b1;
        end
      end else if (lo <= rb) tb_begin[i] = hi;
      else tb_limit[i] = lo;
    end
    return hit ? ST_OK : ST_NOT_FOUND;
  endfunction

  function automatic result_t track_step(op_t op, logic [63:0] a, logic [63:0] len,
                                         logic [2:0] m, logic wr, logic mn);
    result_t r;
    int h;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_REGISTER: r.status = table_insert(a, len, m);
      OP_UNREGISTER: r.status = table_cut(a, len);
      OP_FAULT: begin
        h = -1;
        for (int i = 0; i < Slots; i++)
          if (h < 0 && tb_valid[i] && a >= tb_begin[i] && a < tb_limit[i]) h = i;
        if (h < 0) r.status = ST_NOT_HANDLED;
        else if (mn && !(tb_mode[h] & ModeMinor)) r.status = ST_NOT_HANDLED;
        else if (wr && !(tb_mode[h] & ModeWp)) r.status = ST_NOT_HANDLED;
        else if (bus_err_mode) r.bus_err = 1'b1;
        else if ((ring_wr + 1) % Ring == ring_rd) r.status = ST_RING_FULL;
        else begin
          ring_addr[ring_wr] = a;
          ring_kind[ring_wr] = {mn, wr};
          ring_wr = (ring_wr + 1) % Ring;
        end
      end
      default: begin
        if (ring_rd == ring_wr) r.status = ST_RING_EMPTY;
        else begin
          r.ev_addr = ring_addr[ring_rd];
          r.ev_write = ring_kind[ring_rd][0];
          r.ev_minor = ring_kind[ring_rd][1];
          ring_rd = (ring_rd + 1) % Ring;
        end
      end
    endcase
    return r;
  endfunction

  function automatic int rand_gap();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_word(op_t op, logic [63:0] a, logic [63:0] len,
                           logic [2:0] m = 0, logic wr = 0, logic mn = 0);
    int gap;
    gap = rand_gap();
    // the block is never ready right after an accept, so the added wait costs nothing
    repeat (gap + 1) @(negedge clk);
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b000, mn, wr, m, len, a};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(track_step(op, a, len, m, wr, mn));
    items_sent++;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_mode(logic v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    bus_err_mode = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[69:0]);
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        status_seen[want.status]++;
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.bus_err !== want.bus_err) begin
          $error("sigbus_raised exp %0d got %0d", want.bus_err, got.bus_err); errors++;
        end
        if (got.ev_addr !== want.ev_addr) begin
          $error("event_address exp %h got %h", want.ev_addr, got.ev_addr); errors++;
        end
        if (got.ev_write !== want.ev_write) begin
          $error("event_write exp %0d got %0d", want.ev_write, got.ev_write); errors++;
        end
        if (got.ev_minor !== want.ev_minor) begin
          $error("event_minor exp %0d got %0d", want.ev_minor, got.ev_minor); errors++;
        end
      end
    end
  end

  // receiver stalls, with quiet stretches
  initial begin
    int p;
    forever begin
      @(negedge clk);
      p = $urandom_range(99);
      if (long_stall > 0) begin
        long_stall--;
        m_axis_tready <= 1'b1;
      end else if (p < 3) long_stall = $urandom_range(200, 50);
      else if (p < 8) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(30, 5)) @(negedge clk);
      end else m_axis_tready <= (p >= 30);
    end
  end

  function automatic logic [63:0] pick_addr();
    return {52'($urandom_range(15)), 12'h0} + 64'h1000_0000;
  endfunction

  function automatic logic [63:0] pick_len();
    return {52'($urandom_range(4, 1)), 12'h0};
  endfunction

  task automatic test_bad_ranges();
    send_word(OP_REGISTER, 64'h1000, 64'h0, 3'd1);
    send_word(OP_REGISTER, 64'h1001, Page, 3'd1);
    send_word(OP_REGISTER, 64'h1000, 64'h1800, 3'd1);
    send_word(OP_REGISTER, 64'h1000, Page, 3'd0);
    send_word(OP_REGISTER, 64'hFFFF_FFFF_FFFF_F000, 64'h2000, 3'd7);
    send_word(OP_UNREGISTER, 64'h1000, 64'h0);
    send_word(OP_UNREGISTER, 64'h1000, Page);
    // top page of the address space ends at 2^64 and wraps, so it is refused
    send_word(OP_REGISTER, 64'hFFFF_FFFF_FFFF_F000, Page, 3'd7);
    send_word(OP_FAULT, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 1, 1);
    send_word(OP_READ, 0, 0);
    send_word(OP_READ, 0, 0);
  endtask

  task automatic test_merge_split();
    send_word(OP_REGISTER, 64'h1000, 64'h2000, 3'd1);
    send_word(OP_REGISTER, 64'h2000, 64'h3000, 3'd2);
    send_word(OP_FAULT, 64'h4fff, 0, 0, 1, 0);
    send_word(OP_FAULT, 64'h4fff, 0, 0, 0, 1);
    send_word(OP_UNREGISTER, 64'h2000, Page);
    send_word(OP_FAULT, 64'h2000, 0, 0, 0, 0);
    send_word(OP_UNREGISTER, 64'h0, 64'h2000);
    send_word(OP_UNREGISTER, 64'h4000, 64'h4000);
    send_word(OP_UNREGISTER, 64'h8000_0000, Page);
    send_word(OP_FAULT, 64'h0, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_word(OP_READ, 0, 0);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < Slots + 1; i++)
      send_word(OP_REGISTER, 64'h10_0000 + i * 2 * Page, Page, 3'd7);
    // free a slot, refill it, then split a range when no slot is left for the split part
    send_word(OP_UNREGISTER, 64'h10_0000, Page);
    send_word(OP_REGISTER, 64'h20_0000, 64'h3000, 3'd7);
    send_word(OP_UNREGISTER, 64'h20_1000, Page);
    send_word(OP_UNREGISTER, 64'h0, 64'hFFFF_FFFF_FFFF_F000);
  endtask

  task automatic test_ring_full();
    send_word(OP_REGISTER, 64'h5000, Page, 3'd7);
    for (int i = 0; i < Ring + 1; i++)
      send_word(OP_FAULT, 64'h5000 + i, 0, 0, i[0], i[1]);
    for (int i = 0; i < Ring + 1; i++) send_word(OP_READ, 0, 0);
  endtask

  task automatic test_bus_error();
    write_mode(1'b1);
    send_word(OP_FAULT, 64'h5abc, 0, 0, 1, 1);
    send_word(OP_FAULT, 64'h9000, 0, 0, 0, 0);
    send_word(OP_READ, 0, 0);
  endtask

  task automatic test_random(int n);
    int p;
    op_t op;
    logic [63:0] a, len;
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 150) write_mode(~bus_err_mode);
      if (i == n / 2) drain();  // let the block empty completely once
      p = $urandom_range(99);
      op = op_t'($urandom_range(3));
      if (p < 88) begin
        a = pick_addr();
        len = pick_len();
        if (op == OP_FAULT) a = a + $urandom_range(16'hffff);
      end else begin
        // noise across every bit, with the low 12 bits cleared in some words
        a = {$urandom, $urandom};
        len = {$urandom, $urandom};
        if (p < 94) begin
          a[11:0] = 0; len[11:0] = 0;
        end
      end
      send_word(op, a, len, 3'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    ring_wr = 0; ring_rd = 0; bus_err_mode = 0;
    errors = 0; items_sent = 0; results_seen = 0; long_stall = 0;
    for (int i = 0; i < Slots; i++) begin
      tb_begin[i] = 0; tb_limit[i] = 0; tb_mode[i] = 0; tb_valid[i] = 0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_mode(1'b0);
    test_bad_ranges();
    test_merge_split();
    test_table_full();
    test_ring_full();
    test_bus_error();
    write_mode(1'b0);
    test_random(1270);
    write_mode(1'b0);
    drain();
    $display("sent %0d words, checked %0d results, both bus error settings", items_sent,
             results_seen);
    $display("status counts ok/inv/full/nf/ringfull/nh/empty: %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/frt_pkg.sv
hw/rtl/frt_ram.sv
hw/rtl/frt_ctrl.sv
hw/rtl/frt_dp.sv
hw/rtl/fault_range_tracker.sv
dv/fault_range_tracker_test.sv
